// ----- rtl/core/pli_pkg.sv -----
// ----------------------------------------------------------------------------
// pli_pkg
// Shared types and constants for the piecewise linear interpolation table.
// ----------------------------------------------------------------------------
package pli_pkg;

   localparam int MAX_POINTS    = 64;
   localparam int X_WIDTH       = 16;
   localparam int Y_WIDTH       = 16;
   localparam int ADDR_WIDTH    = $clog2(MAX_POINTS);
   localparam int CNT_WIDTH     = $clog2(MAX_POINTS + 1);
   localparam int PROD_WIDTH    = X_WIDTH + Y_WIDTH;
   localparam int DIV_CNT_WIDTH = $clog2(PROD_WIDTH);

   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      STATUS_LOADED = 3'd0,
      STATUS_EXACT  = 3'd1,
      STATUS_INTERP = 3'd2,
      STATUS_RANGE  = 3'd3,
      STATUS_FULL   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_EVAL,
      ST_MUL,
      ST_DIV,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic signed [X_WIDTH-1:0] x;
      logic signed [Y_WIDTH-1:0] y;
   } point_type;

endpackage

// ----- rtl/core/piecewise_linear_interp_table.sv -----
// Load or empty-table query: the result is registered 1 cycle after acceptance.
// Query over N points: SCAN, DRAIN and EVAL, then the response on an exact match
// or out of range; interpolating adds operand set-up and the 32-step divider.
// One transaction at a time: the next is taken the cycle after the result is
// registered, later while a stalled response holds the result register.
// Synchronous reset empties the table; the point memory itself is not cleared.
// ----------------------------------------------------------------------------
// piecewise_linear_interp_table
// Breakpoint table with bracket scan and linear interpolation between points.
// ----------------------------------------------------------------------------
module piecewise_linear_interp_table (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_cmd,
   input  logic signed [pli_pkg::X_WIDTH-1:0]  req_x_value,
   input  logic signed [pli_pkg::Y_WIDTH-1:0]  req_y_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [pli_pkg::Y_WIDTH-1:0]  rsp_y_result,
   output logic [2:0]                          rsp_status
);
   import pli_pkg::*;

   state_type                 state_ff, state_in;
   logic [CNT_WIDTH-1:0]      count_ff;
   logic [ADDR_WIDTH-1:0]     idx_ff;
   logic                      rd_valid_ff;
   logic signed [X_WIDTH-1:0] query_x_ff;

   logic                      exact_ff, have_lo_ff, have_hi_ff;
   logic signed [Y_WIDTH-1:0] ey_ff, ya_ff, yc_ff;
   logic signed [X_WIDTH-1:0] xa_ff, xc_ff;

   logic [X_WIDTH-1:0]        dx_ff, span_ff;
   logic [Y_WIDTH-1:0]        mag_ff;
   logic                      neg_ff;

   logic signed [Y_WIDTH-1:0] res_y_ff;
   status_type                res_status_ff;

   logic                      rsp_valid_ff;
   logic signed [Y_WIDTH-1:0] rsp_y_ff;
   status_type                rsp_status_ff;

   logic                      req_fire;
   logic                      rsp_free;
   logic                      table_full;
   logic                      last_addr;
   logic                      mem_wr, mem_rd, div_start, div_done;
   point_type                 wr_point, rd_point;
   logic [PROD_WIDTH-1:0]     product;
   logic [PROD_WIDTH-1:0]     quotient;

   logic signed [X_WIDTH:0]   dx_wide, span_wide;
   logic signed [Y_WIDTH:0]   dy_wide, mag_wide;
   logic signed [Y_WIDTH:0]   sum_wide;
   logic [Y_WIDTH-1:0]        q_narrow;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_fire   = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign table_full = (count_ff >= CNT_WIDTH'(MAX_POINTS));
   assign last_addr  = (idx_ff == ADDR_WIDTH'(count_ff - 1'b1));

   assign wr_point.x = req_x_value;
   assign wr_point.y = req_y_value;

   pli_point_ram u_ram (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (count_ff[ADDR_WIDTH-1:0]),
      .wr_data (wr_point),
      .rd_en   (mem_rd),
      .rd_addr (idx_ff),
      .rd_data (rd_point)
   );

   assign product = PROD_WIDTH'(mag_ff) * PROD_WIDTH'(dx_ff);

   pli_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product),
      .divisor  (span_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // next state and control strobes
   always_comb begin
      state_in  = state_ff;
      mem_wr    = 1'b0;
      mem_rd    = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_cmd == CMD_LOAD) begin
                  mem_wr   = !table_full;
                  state_in = ST_RESP;
               end else if (count_ff == '0) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            mem_rd = 1'b1;
            if (last_addr) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_EVAL;
         ST_EVAL: begin
            if (exact_ff || !(have_lo_ff && have_hi_ff)) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= mem_rd;
         if (mem_wr) begin
            count_ff <= count_ff + 1'b1;
         end
         if (state_ff == ST_RESP && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      dx_wide   = {query_x_ff[X_WIDTH-1], query_x_ff} - {xa_ff[X_WIDTH-1], xa_ff};
      span_wide = {xc_ff[X_WIDTH-1], xc_ff} - {xa_ff[X_WIDTH-1], xa_ff};
      dy_wide   = {yc_ff[Y_WIDTH-1], yc_ff} - {ya_ff[Y_WIDTH-1], ya_ff};
      mag_wide  = dy_wide[Y_WIDTH] ? -dy_wide : dy_wide;
      q_narrow  = quotient[Y_WIDTH-1:0];
      sum_wide  = neg_ff ? ({ya_ff[Y_WIDTH-1], ya_ff} - {1'b0, q_narrow})
                         : ({ya_ff[Y_WIDTH-1], ya_ff} + {1'b0, q_narrow});
   end

   // datapath: bracket scan, operand set-up and result staging
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_fire) begin
         query_x_ff <= req_x_value;
         idx_ff     <= '0;
         exact_ff   <= 1'b0;
         have_lo_ff <= 1'b0;
         have_hi_ff <= 1'b0;
         res_y_ff   <= '0;
         if (req_cmd == CMD_LOAD) begin
            res_status_ff <= table_full ? STATUS_FULL : STATUS_LOADED;
         end else begin
            res_status_ff <= STATUS_RANGE;
         end
      end
      if (mem_rd) begin
         idx_ff <= idx_ff + 1'b1;
      end
      // later points win on ties, as the table is scanned in load order
      if (rd_valid_ff) begin
         if (rd_point.x == query_x_ff) begin
            exact_ff <= 1'b1;
            ey_ff    <= rd_point.y;
         end else if (rd_point.x < query_x_ff) begin
            if (!have_lo_ff || rd_point.x >= xa_ff) begin
               have_lo_ff <= 1'b1;
               xa_ff      <= rd_point.x;
               ya_ff      <= rd_point.y;
            end
         end else begin
            if (!have_hi_ff || rd_point.x <= xc_ff) begin
               have_hi_ff <= 1'b1;
               xc_ff      <= rd_point.x;
               yc_ff      <= rd_point.y;
            end
         end
      end
      if (state_ff == ST_EVAL) begin
         dx_ff   <= dx_wide[X_WIDTH-1:0];
         span_ff <= span_wide[X_WIDTH-1:0];
         mag_ff  <= mag_wide[Y_WIDTH-1:0];
         neg_ff  <= dy_wide[Y_WIDTH];
         if (exact_ff) begin
            res_y_ff      <= ey_ff;
            res_status_ff <= STATUS_EXACT;
         end
      end
      if (state_ff == ST_DIV && div_done) begin
         res_y_ff      <= sum_wide[Y_WIDTH-1:0];
         res_status_ff <= STATUS_INTERP;
      end
      if (state_ff == ST_RESP && rsp_free) begin
         rsp_y_ff      <= res_y_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_y_result = rsp_y_ff;
   assign rsp_status   = rsp_status_ff;

endmodule

// ----- rtl/core/pli_point_ram.sv -----
// ----------------------------------------------------------------------------
// pli_point_ram
// Breakpoint store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pli_point_ram (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [pli_pkg::ADDR_WIDTH-1:0]  wr_addr,
   input  pli_pkg::point_type              wr_data,
   input  logic                            rd_en,
   input  logic [pli_pkg::ADDR_WIDTH-1:0]  rd_addr,
   output pli_pkg::point_type              rd_data
);
   import pli_pkg::*;

   point_type mem [MAX_POINTS];
   point_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/pli_divider.sv -----
// ----------------------------------------------------------------------------
// pli_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pli_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [pli_pkg::PROD_WIDTH-1:0]  dividend,
   input  logic [pli_pkg::X_WIDTH-1:0]     divisor,
   output logic                            done,
   output logic [pli_pkg::PROD_WIDTH-1:0]  quotient
);
   import pli_pkg::*;

   logic                      busy_ff;
   logic                      done_ff;
   logic [DIV_CNT_WIDTH-1:0]  cnt_ff;
   logic [PROD_WIDTH-1:0]     quot_ff;
   logic [X_WIDTH-1:0]        rem_ff;
   logic [X_WIDTH-1:0]        divisor_ff;
   logic [X_WIDTH:0]          rem_shift;
   logic [X_WIDTH:0]          rem_diff;
   logic                      fits;

   always_comb begin
      rem_shift = {rem_ff, quot_ff[PROD_WIDTH-1]};
      rem_diff  = rem_shift - {1'b0, divisor_ff};
      fits      = (rem_shift >= {1'b0, divisor_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_WIDTH'(PROD_WIDTH - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff    <= dividend;
         rem_ff     <= '0;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         quot_ff <= {quot_ff[PROD_WIDTH-2:0], fits};
         rem_ff  <= fits ? rem_diff[X_WIDTH-1:0] : rem_shift[X_WIDTH-1:0];
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the breakpoint table: loads and queries are driven with
// random idling on both sides. A scoreboard keeps its own copy of the table
// and works out each expected response, then checks responses in order.
// ----------------------------------------------------------------------------

typedef logic signed [pli_pkg::X_WIDTH-1:0] x_fix_type;
typedef logic signed [pli_pkg::Y_WIDTH-1:0] y_fix_type;

class interp_scoreboard;
   x_fix_type bp_x [pli_pkg::MAX_POINTS];
   y_fix_type bp_y [pli_pkg::MAX_POINTS];
   int bp_count;
   y_fix_type want_y [$];
   pli_pkg::status_type want_status [$];
   int errors;
   int seen [5];

   function new();
      bp_count = 0;
      errors = 0;
      foreach (seen[i]) seen[i] = 0;
   endfunction

   // work out the response for an accepted transaction and queue it
   function void note_request(pli_pkg::cmd_type op, x_fix_type xv, y_fix_type yv);
      longint xq, px, xa, ya, xc, yc, hit_y, dy, mag, q, res;
      bit hit, have_lo, have_hi;
      pli_pkg::status_type st;
      res = 0;
      if (op == pli_pkg::CMD_LOAD) begin
         if (bp_count < pli_pkg::MAX_POINTS) begin
            bp_x[bp_count] = xv;
            bp_y[bp_count] = yv;
            bp_count++;
            st = pli_pkg::STATUS_LOADED;
         end else begin
            st = pli_pkg::STATUS_FULL;
         end
      end else begin
         xq = xv;
         hit = 0; have_lo = 0; have_hi = 0;
         hit_y = 0; xa = 0; ya = 0; xc = 0; yc = 0;
         // later points win ties, hence the non-strict compares
         for (int i = 0; i < bp_count; i++) begin
            px = bp_x[i];
            if (px == xq) begin
               hit = 1;
               hit_y = bp_y[i];
            end else if (px < xq) begin
               if (!have_lo || px >= xa) begin
                  have_lo = 1; xa = px; ya = bp_y[i];
               end
            end else begin
               if (!have_hi || px <= xc) begin
                  have_hi = 1; xc = px; yc = bp_y[i];
               end
            end
         end
         if (hit) begin
            res = hit_y;
            st = pli_pkg::STATUS_EXACT;
         end else if (have_lo && have_hi) begin
            dy = yc - ya;
            mag = (dy < 0) ? -dy : dy;
            q = (mag * (xq - xa)) / (xc - xa);
            res = (dy < 0) ? ya - q : ya + q;
            st = pli_pkg::STATUS_INTERP;
         end else begin
            st = pli_pkg::STATUS_RANGE;
         end
      end
      want_y = {want_y, y_fix_type'(res)};
      want_status = {want_status, st};
      seen[st]++;
   endfunction

   function void check_response(y_fix_type yr, logic [2:0] st);
      y_fix_type ey;
      pli_pkg::status_type es;
      if (want_y.size() == 0) begin
         $display("%0t: unexpected response, got y_result %0d status %0d", $time, yr, st);
         errors++;
         return;
      end
      ey = want_y.pop_front();
      es = want_status.pop_front();
      if (st !== es) begin
         $display("%0t: status mismatch, expected %0d, got %0d", $time, es, st);
         errors++;
      end
      if (yr !== ey) begin
         $display("%0t: y_result mismatch, expected %0d, got %0d", $time, ey, yr);
         errors++;
      end
   endfunction

   function int pending();
      return want_y.size();
   endfunction
endclass

module tb_top;
   import pli_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int ITEM_TARGET = 1050;

   logic      clock;
   logic      reset;
   logic      req_valid;
   logic      req_stall;
   logic      req_cmd;
   x_fix_type req_x_value;
   y_fix_type req_y_value;
   logic      rsp_valid;
   logic      rsp_stall;
   y_fix_type rsp_y_result;
   logic [2:0] rsp_status;

   interp_scoreboard sb;
   int  sent;
   bit  steady;
   int  quiet_cycles;

   piecewise_linear_interp_table dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_cmd      (req_cmd),
      .req_x_value  (req_x_value),
      .req_y_value  (req_y_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_y_result (rsp_y_result),
      .rsp_status   (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= !steady && ($urandom_range(0, 99) < 18);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         sb.check_response(rsp_y_result, rsp_status);
      end
   end

   // nothing accepted on either side for too long means the block is stuck
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_item(input cmd_type op, input x_fix_type xv, input y_fix_type yv);
      steady = (sent >= 400 && sent < 560);
      while (!steady && $urandom_range(0, 99) < 18) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_cmd     <= op;
      req_x_value <= xv;
      req_y_value <= yv;
      do @(posedge clock); while (req_stall);
      sb.note_request(op, xv, yv);
      sent++;
      @(negedge clock);
   endtask

   // query x: stored points, their neighbours, or anything at all
   task automatic random_query();
      x_fix_type qx;
      int pick;
      pick = $urandom_range(0, 99);
      qx = x_fix_type'($urandom);
      if (sb.bp_count > 0 && pick < 25) begin
         qx = sb.bp_x[$urandom_range(0, sb.bp_count - 1)];
      end else if (sb.bp_count > 0 && pick < 40) begin
         qx = x_fix_type'(sb.bp_x[$urandom_range(0, sb.bp_count - 1)]
                          + ((pick & 1) ? 1 : -1));
      end
      send_item(CMD_QUERY, qx, y_fix_type'($urandom));
   endtask

   initial begin
      x_fix_type lx;
      sb = new();
      sent = 0;
      steady = 0;
      quiet_cycles = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = CMD_LOAD;
      req_x_value = '0;
      req_y_value = '0;
      rsp_stall = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty table, edges, duplicates, ignored y on queries
      send_item(CMD_QUERY, 0, 16'sh7fff);
      send_item(CMD_LOAD, 256, 512);
      send_item(CMD_QUERY, 256, 16'sh8000);
      send_item(CMD_QUERY, 16'sh8000, 0);
      send_item(CMD_QUERY, 16'sh7fff, 0);
      send_item(CMD_LOAD, 1024, 16'sh8000);
      send_item(CMD_QUERY, 640, 0);
      send_item(CMD_QUERY, 1023, 0);
      send_item(CMD_LOAD, 256, 1000);
      send_item(CMD_QUERY, 256, 0);
      send_item(CMD_QUERY, 257, 0);
      send_item(CMD_LOAD, 1024, 16'sh7fff);
      send_item(CMD_QUERY, 1023, 0);
      send_item(CMD_QUERY, 1024, 16'sh7fff);
      send_item(CMD_LOAD, x_fix_type'(-256), 16'sh7fff);
      send_item(CMD_QUERY, x_fix_type'(-255), 0);
      send_item(CMD_QUERY, 0, 0);
      send_item(CMD_QUERY, x_fix_type'(-257), 0);
      send_item(CMD_QUERY, 1025, 0);

      // fill the table within a window so that out-of-range queries remain
      while (sb.bp_count < MAX_POINTS - 2) begin
         if ($urandom_range(0, 99) < 30) begin
            if ($urandom_range(0, 99) < 15) begin
               lx = sb.bp_x[$urandom_range(0, sb.bp_count - 1)];
            end else begin
               lx = x_fix_type'(int'($urandom_range(0, 40000)) - 20000);
            end
            send_item(CMD_LOAD, lx, y_fix_type'($urandom));
         end else begin
            random_query();
         end
      end

      // last two slots take the extremes of x, then the table overflows
      send_item(CMD_LOAD, 16'sh8000, y_fix_type'($urandom));
      send_item(CMD_LOAD, 16'sh7fff, y_fix_type'($urandom));
      send_item(CMD_QUERY, 16'sh8000, 0);
      send_item(CMD_QUERY, 16'sh7fff, 0);
      repeat (3) send_item(CMD_LOAD, x_fix_type'($urandom), y_fix_type'($urandom));

      while (sent < ITEM_TARGET) begin
         if ($urandom_range(0, 99) < 10) begin
            send_item(CMD_LOAD, x_fix_type'($urandom), y_fix_type'($urandom));
         end else begin
            random_query();
         end
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("Ran %0d transactions: %0d loads, %0d dropped on a full table,",
               sent, sb.seen[STATUS_LOADED], sb.seen[STATUS_FULL]);
      $display("%0d exact matches, %0d interpolations, %0d empty or out-of-range queries",
               sb.seen[STATUS_EXACT], sb.seen[STATUS_INTERP], sb.seen[STATUS_RANGE]);
      if (sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/pli_pkg.sv
rtl/core/pli_point_ram.sv
rtl/core/pli_divider.sv
rtl/core/piecewise_linear_interp_table.sv
sim/tb_top.sv
